[rtl/rti_pkg.sv]
// rti_pkg: shared widths, register codes and the control struct of the
// ray/triangle intersection unit; used by rti_div and the top level
package rti_pkg;

  // coordinate and intermediate widths
  localparam int COORD_W = 32;
  localparam int EDGE_W  = 33;
  localparam int PROD_W  = 66;
  localparam int NRM_W   = 67;
  localparam int WIDE_W  = 68;
  localparam int SPLIT_W = 34;
  localparam int PH_W    = 67;
  localparam int DOT_W   = 104;
  localparam int DIST_W  = 32;
  localparam int QB      = DIST_W - 1;
  localparam int CFG_AW  = 5;

  // saturation limits of the distance
  localparam logic [DIST_W-1:0] DIST_MAX = 32'h7FFF_FFFF;
  localparam logic [DIST_W-1:0] DIST_MIN = 32'h8000_0000;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_ORG_X = 3'd0,
    REG_ORG_Y = 3'd1,
    REG_ORG_Z = 3'd2,
    REG_DIR_X = 3'd3,
    REG_DIR_Y = 3'd4,
    REG_DIR_Z = 3'd5
  } reg_idx_t;

  // per-triangle flags that travel with the divider pipeline
  typedef struct packed {
    logic hit;
    logic negq;
    logic zero;
    logic ovf;
  } rti_ctl_t;

endpackage

[rtl/rti_div.sv]
// rti_div: pipelined restoring divider for the distance, one quotient bit
// per stage, with saturation and sign; depends on rti_pkg
module rti_div import rti_pkg::*; #(
  parameter int NUM_W = 120,
  parameter int DEN_W = 104
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  rti_ctl_t          in_ctl,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  output logic              out_vld,
  output logic              out_hit,
  output logic [DIST_W-1:0] out_dist
);

  localparam int RW = DEN_W + DIST_W;

  logic [RW-1:0]    rem_r [QB+1];
  logic [DEN_W-1:0] den_r [QB+1];
  logic [QB-1:0]    quo_r [QB+1];
  rti_ctl_t         ctl_r [QB+1];
  logic             vld_r [QB+1];

  logic              out_vld_r;
  logic              out_hit_r;
  logic [DIST_W-1:0] out_dist_r;
  logic [DIST_W-1:0] dist_nxt;
  rti_ctl_t          ctl0_nxt;

  // overflow check: magnitude of at least 2^31 saturates
  always_comb begin
    ctl0_nxt     = in_ctl;
    ctl0_nxt.ovf = RW'(in_num) >= (RW'(in_den) << QB);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    rem_r[0] <= RW'(in_num);
    den_r[0] <= in_den;
    quo_r[0] <= '0;
    ctl_r[0] <= ctl0_nxt;
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 1; k <= QB; k++) begin : g_step
    localparam int B = QB - k;
    logic [RW-1:0] trial;
    logic          ge;
    assign trial = RW'(den_r[k-1]) << B;
    assign ge    = rem_r[k-1] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
      rem_r[k] <= ge ? (rem_r[k-1] - trial) : rem_r[k-1];
      quo_r[k] <= quo_r[k-1] | (QB'(ge) << B);
      den_r[k] <= den_r[k-1];
      ctl_r[k] <= ctl_r[k-1];
    end
  end

  // sign, saturation and zero determinant
  always_comb begin
    if (ctl_r[QB].zero) begin
      dist_nxt = '0;
    end else if (ctl_r[QB].ovf) begin
      dist_nxt = ctl_r[QB].negq ? DIST_MIN : DIST_MAX;
    end else if (ctl_r[QB].negq) begin
      dist_nxt = DIST_W'(0) - {1'b0, quo_r[QB]};
    end else begin
      dist_nxt = {1'b0, quo_r[QB]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[QB];
    end
    out_hit_r  <= ctl_r[QB].hit;
    out_dist_r <= dist_nxt;
  end

  assign out_vld  = out_vld_r;
  assign out_hit  = out_hit_r;
  assign out_dist = out_dist_r;

  // remainder ends below the divisor when the quotient is in range
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[QB] && !ctl_r[QB].ovf && !ctl_r[QB].zero |-> rem_r[QB] < RW'(den_r[QB]))
    else $error("divider remainder not below divisor");

  // a zero determinant never reports a hit
  a_zero_nohit: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] && ctl_r[0].zero |-> !ctl_r[0].hit)
    else $error("hit with zero determinant");

endmodule

[rtl/ray_triangle_intersect_unit.sv]
// ray_triangle_intersect_unit: fixed-point ray/triangle test against a ray
// held in apb registers; depends on rti_pkg and rti_div
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------
//  input    | start, busy (always 0)| in_vertex_{a,b,c}_{x,y,z}
//  result   | out_valid strobe      | out_hit, out_distance
//  config   | psel, penable, pwrite | paddr, pwdata, prdata, pready
//
// one triangle per cycle; its result strobes on out_valid after the last stage
// pipeline: 7 arithmetic stages plus 33 divider stages (input register,
// 31 quotient-bit stages, output register)
// rst_n clears the ray registers and all stage valid bits
// the receiver cannot stall, so the pipeline never stops and busy stays low
module ray_triangle_intersect_unit import rti_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] in_vertex_a_x,
  input  logic signed [COORD_W-1:0] in_vertex_a_y,
  input  logic signed [COORD_W-1:0] in_vertex_a_z,
  input  logic signed [COORD_W-1:0] in_vertex_b_x,
  input  logic signed [COORD_W-1:0] in_vertex_b_y,
  input  logic signed [COORD_W-1:0] in_vertex_b_z,
  input  logic signed [COORD_W-1:0] in_vertex_c_x,
  input  logic signed [COORD_W-1:0] in_vertex_c_y,
  input  logic signed [COORD_W-1:0] in_vertex_c_z,
  output logic                      out_valid,
  output logic                      out_hit,
  output logic signed [DIST_W-1:0]  out_distance,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_AW-1:0]         paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int NUM_W = DOT_W + FRAC_BITS;
  localparam logic [79:0] EPS_NUM = (80'd1 << (3 * FRAC_BITS)) + 80'd999999;
  localparam logic signed [DOT_W-1:0] EPS = DOT_W'(EPS_NUM / 80'd1000000);

  // ray registers
  logic signed [COORD_W-1:0] org_r [3];
  logic signed [COORD_W-1:0] dir_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        org_r[i] <= '0;
        dir_r[i] <= '0;
      end
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[CFG_AW-1:2]))
        REG_ORG_X: org_r[0] <= pwdata;
        REG_ORG_Y: org_r[1] <= pwdata;
        REG_ORG_Z: org_r[2] <= pwdata;
        REG_DIR_X: dir_r[0] <= pwdata;
        REG_DIR_Y: dir_r[1] <= pwdata;
        REG_DIR_Z: dir_r[2] <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx_t'(paddr[CFG_AW-1:2]))
      REG_ORG_X: prdata = org_r[0];
      REG_ORG_Y: prdata = org_r[1];
      REG_ORG_Z: prdata = org_r[2];
      REG_DIR_X: prdata = dir_r[0];
      REG_DIR_Y: prdata = dir_r[1];
      REG_DIR_Z: prdata = dir_r[2];
      default:   prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign busy   = 1'b0;

  // vertex and direction vectors
  logic signed [COORD_W-1:0] va [3];
  logic signed [COORD_W-1:0] vb [3];
  logic signed [COORD_W-1:0] vc [3];
  logic signed [EDGE_W-1:0]  dx [3];

  assign va[0] = in_vertex_a_x;
  assign va[1] = in_vertex_a_y;
  assign va[2] = in_vertex_a_z;
  assign vb[0] = in_vertex_b_x;
  assign vb[1] = in_vertex_b_y;
  assign vb[2] = in_vertex_b_z;
  assign vc[0] = in_vertex_c_x;
  assign vc[1] = in_vertex_c_y;
  assign vc[2] = in_vertex_c_z;

  for (genvar i = 0; i < 3; i++) begin : g_dir
    assign dx[i] = EDGE_W'(dir_r[i]);
  end

  // stage 1: edges and origin offset
  logic                     s1_vld_r;
  logic signed [EDGE_W-1:0] s1_e1_r [3];
  logic signed [EDGE_W-1:0] s1_e2_r [3];
  logic signed [EDGE_W-1:0] s1_ao_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start;
    end
    for (int i = 0; i < 3; i++) begin
      s1_e1_r[i] <= EDGE_W'(vb[i]) - EDGE_W'(va[i]);
      s1_e2_r[i] <= EDGE_W'(vc[i]) - EDGE_W'(va[i]);
      s1_ao_r[i] <= EDGE_W'(org_r[i]) - EDGE_W'(va[i]);
    end
  end

  // stage 2: cross product terms for the normal and ao x dir
  logic                     s2_vld_r;
  logic signed [PROD_W-1:0] pn_r [6];
  logic signed [PROD_W-1:0] pd_r [6];
  logic signed [EDGE_W-1:0] s2_e1_r [3];
  logic signed [EDGE_W-1:0] s2_e2_r [3];
  logic signed [EDGE_W-1:0] s2_ao_r [3];

  for (genvar j = 0; j < 3; j++) begin : g_cross
    localparam int P = (j + 1) % 3;
    localparam int Q = (j + 2) % 3;
    always_ff @(posedge clk) begin
      pn_r[2*j]   <= s1_e1_r[P] * s1_e2_r[Q];
      pn_r[2*j+1] <= s1_e1_r[Q] * s1_e2_r[P];
      pd_r[2*j]   <= s1_ao_r[P] * dx[Q];
      pd_r[2*j+1] <= s1_ao_r[Q] * dx[P];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_e1_r <= s1_e1_r;
    s2_e2_r <= s1_e2_r;
    s2_ao_r <= s1_ao_r;
  end

  // stage 3: normal and dao vectors
  logic                     s3_vld_r;
  logic signed [NRM_W-1:0]  nrm_r [3];
  logic signed [NRM_W-1:0]  dao_r [3];
  logic signed [EDGE_W-1:0] s3_e1_r [3];
  logic signed [EDGE_W-1:0] s3_e2_r [3];
  logic signed [EDGE_W-1:0] s3_ao_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    for (int j = 0; j < 3; j++) begin
      nrm_r[j] <= NRM_W'(pn_r[2*j]) - NRM_W'(pn_r[2*j+1]);
      dao_r[j] <= NRM_W'(pd_r[2*j]) - NRM_W'(pd_r[2*j+1]);
    end
    s3_e1_r <= s2_e1_r;
    s3_e2_r <= s2_e2_r;
    s3_ao_r <= s2_ao_r;
  end

  // dot operands: 0 det, 1 t, 2 u, 3 v
  logic signed [EDGE_W-1:0] dot_x [4][3];
  logic signed [WIDE_W-1:0] dot_w [4][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dot_x[0][i] = dx[i];
      dot_w[0][i] = WIDE_W'(nrm_r[i]);
      dot_x[1][i] = s3_ao_r[i];
      dot_w[1][i] = WIDE_W'(nrm_r[i]);
      dot_x[2][i] = s3_e2_r[i];
      dot_w[2][i] = WIDE_W'(dao_r[i]);
      dot_x[3][i] = s3_e1_r[i];
      dot_w[3][i] = WIDE_W'(dao_r[i]);
    end
  end

  // stage 4: split partial products of the dot terms
  logic                     s4_vld_r;
  logic signed [WIDE_W-1:0] pl_r [4][3];
  logic signed [PH_W-1:0]   ph_r [4][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++) begin
        pl_r[k][i] <= dot_x[k][i] * $signed({1'b0, dot_w[k][i][SPLIT_W-1:0]});
        ph_r[k][i] <= dot_x[k][i] * $signed(dot_w[k][i][WIDE_W-1:SPLIT_W]);
      end
    end
  end

  // stage 5: recombine partial products
  logic                    s5_vld_r;
  logic signed [DOT_W-1:0] term_r [4][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= s4_vld_r;
    end
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++) begin
        term_r[k][i] <= (DOT_W'(ph_r[k][i]) <<< SPLIT_W) + DOT_W'(pl_r[k][i]);
      end
    end
  end

  // stage 6: determinant and numerators
  logic                    s6_vld_r;
  logic signed [DOT_W-1:0] det_r;
  logic signed [DOT_W-1:0] t_r;
  logic signed [DOT_W-1:0] u_r;
  logic signed [DOT_W-1:0] v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else begin
      s6_vld_r <= s5_vld_r;
    end
    det_r <= DOT_W'(0) - (term_r[0][0] + term_r[0][1] + term_r[0][2]);
    t_r   <= term_r[1][0] + term_r[1][1] + term_r[1][2];
    u_r   <= term_r[2][0] + term_r[2][1] + term_r[2][2];
    v_r   <= DOT_W'(0) - (term_r[3][0] + term_r[3][1] + term_r[3][2]);
  end

  // stage 7: hit test, signs and magnitudes for the divider
  logic signed [DOT_W:0]   uv_sum;
  logic [DOT_W-1:0]        t_mag;
  rti_ctl_t                ctl_nxt;
  logic                    s7_vld_r;
  rti_ctl_t                s7_ctl_r;
  logic [NUM_W-1:0]        s7_num_r;
  logic [DOT_W-1:0]        s7_den_r;

  assign uv_sum = (DOT_W+1)'(u_r) + (DOT_W+1)'(v_r);
  assign t_mag  = t_r[DOT_W-1] ? (DOT_W'(0) - t_r) : t_r;

  always_comb begin
    ctl_nxt.hit  = (det_r >= EPS) && !t_r[DOT_W-1] && !u_r[DOT_W-1] &&
                   !v_r[DOT_W-1] && ((DOT_W+1)'(det_r) >= uv_sum);
    ctl_nxt.negq = t_r[DOT_W-1] ^ det_r[DOT_W-1];
    ctl_nxt.zero = det_r == '0;
    ctl_nxt.ovf  = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
    end else begin
      s7_vld_r <= s6_vld_r;
    end
    s7_ctl_r <= ctl_nxt;
    s7_num_r <= {t_mag, FRAC_BITS'(0)};
    s7_den_r <= det_r[DOT_W-1] ? (DOT_W'(0) - det_r) : det_r;
  end

  // distance division
  logic [DIST_W-1:0] div_dist;

  rti_div #(
    .NUM_W (NUM_W),
    .DEN_W (DOT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s7_vld_r),
    .in_ctl   (s7_ctl_r),
    .in_num   (s7_num_r),
    .in_den   (s7_den_r),
    .out_vld  (out_valid),
    .out_hit  (out_hit),
    .out_dist (div_dist)
  );

  assign out_distance = div_dist;

  // a hit lies ahead of the origin
  a_hit_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_distance[DIST_W-1])
    else $error("hit with negative distance");

  // zero determinant is flagged and never hits
  a_det_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s6_vld_r && (det_r == '0) |=> s7_vld_r && s7_ctl_r.zero && !s7_ctl_r.hit)
    else $error("zero determinant not flagged");

endmodule

[tb/sv/ray_triangle_intersect_unit_tb.sv]
// ray_triangle_intersect_unit_tb: self-checking bench for the ray/triangle unit;
// depends on rti_pkg and ray_triangle_intersect_unit, programs rays over the
// apb port and streams triangles, checking each hit flag and distance
module ray_triangle_intersect_unit_tb;
  import rti_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC     = 16;
  localparam int LATENCY  = 40;
  localparam int LIMIT    = 400000;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [31:0]  crd_t;

  // expected outcome of one triangle
  typedef struct packed {
    logic hit;
    crd_t distance;
  } isect_t;

  // scoreboard: own copy of the ray, queue of pending intersections
  class isect_board;
    crd_t   ray[6];
    isect_t pending[$];
    int     errors;
    int     hits_seen;
    int     checked;

    function new();
      foreach (ray[i]) ray[i] = '0;
      errors = 0;
      hits_seen = 0;
      checked = 0;
    endfunction

    // exact Moller-Trumbore on wide integers
    function void note_triangle(crd_t v[9]);
      wide_t a[3], e1[3], e2[3], nrm[3], o[3], d[3], ao[3], dao[3];
      wide_t det, unum, vnum, tnum, eps, num, mag;
      isect_t res;
      for (int i = 0; i < 3; i++) begin
        a[i]  = wide_t'(v[i]);
        e1[i] = wide_t'(v[3+i]) - a[i];
        e2[i] = wide_t'(v[6+i]) - a[i];
        o[i]  = wide_t'(ray[i]);
        d[i]  = wide_t'(ray[3+i]);
        ao[i] = o[i] - a[i];
      end
      nrm[0] = e1[1]*e2[2] - e1[2]*e2[1];
      nrm[1] = e1[2]*e2[0] - e1[0]*e2[2];
      nrm[2] = e1[0]*e2[1] - e1[1]*e2[0];
      det = -(d[0]*nrm[0] + d[1]*nrm[1] + d[2]*nrm[2]);
      dao[0] = ao[1]*d[2] - ao[2]*d[1];
      dao[1] = ao[2]*d[0] - ao[0]*d[2];
      dao[2] = ao[0]*d[1] - ao[1]*d[0];
      unum = e2[0]*dao[0] + e2[1]*dao[1] + e2[2]*dao[2];
      vnum = -(e1[0]*dao[0] + e1[1]*dao[1] + e1[2]*dao[2]);
      tnum = ao[0]*nrm[0] + ao[1]*nrm[1] + ao[2]*nrm[2];
      eps = ((wide_t'(1) <<< (3*FRAC)) + 999999) / 1000000;
      res.hit = (det >= eps) && (tnum >= 0) && (unum >= 0) && (vnum >= 0) &&
                (unum + vnum <= det);
      res.distance = '0;
      if (det != 0) begin
        num = tnum <<< FRAC;
        mag = (num < 0 ? -num : num) / (det < 0 ? -det : det);
        if ((num < 0) != (det < 0))
          res.distance = (mag > 128'sh8000_0000) ? DIST_MIN : crd_t'(-mag);
        else
          res.distance = (mag > 128'sh7FFF_FFFF) ? DIST_MAX : crd_t'(mag);
      end
      pending.push_back(res);
    endfunction

    function void check_result(logic hit, crd_t distance);
      isect_t want;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result hit=%0b distance=%h", $time, hit, distance);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (hit) hits_seen++;
      if (want.hit !== hit) begin
        $display("%0t: hit mismatch expected %0b actual %0b", $time, want.hit, hit);
        errors++;
      end
      if (want.distance !== distance) begin
        $display("%0t: distance mismatch expected %h actual %h", $time,
                 want.distance, distance);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, start, busy;
  crd_t vtx[9];
  logic out_valid, out_hit;
  crd_t out_distance;
  logic psel, penable, pwrite, pready;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata, prdata;

  isect_board board;
  int idle_pct;
  int sent;
  int cycles;

  ray_triangle_intersect_unit #(.FRAC_BITS(FRAC)) u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_vertex_a_x(vtx[0]), .in_vertex_a_y(vtx[1]), .in_vertex_a_z(vtx[2]),
    .in_vertex_b_x(vtx[3]), .in_vertex_b_y(vtx[4]), .in_vertex_b_z(vtx[5]),
    .in_vertex_c_x(vtx[6]), .in_vertex_c_y(vtx[7]), .in_vertex_c_z(vtx[8]),
    .out_valid(out_valid), .out_hit(out_hit), .out_distance(out_distance),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // input monitor: record each accepted transaction
  always @(posedge clk) begin
    if (rst_n && start && !busy) board.note_triangle(vtx);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_result(out_hit, out_distance);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // apb write, setup then access phase
  task automatic write_ray(reg_idx_t idx, crd_t val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(4 * int'(idx));
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    board.ray[idx] = val;
  endtask

  // wait for all pending intersections, then let the pipeline drain
  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic set_ray(crd_t ox, crd_t oy, crd_t oz, crd_t dx, crd_t dy, crd_t dz);
    drain();
    write_ray(REG_ORG_X, ox);
    write_ray(REG_ORG_Y, oy);
    write_ray(REG_ORG_Z, oz);
    write_ray(REG_DIR_X, dx);
    write_ray(REG_DIR_Y, dy);
    write_ray(REG_DIR_Z, dz);
  endtask

  // one triangle transaction, with random sender gaps
  task automatic send_tri(crd_t v[9]);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    foreach (v[i]) vtx[i] <= v[i];
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic end_burst();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // triangle placed around a point along the ray, random winding
  task automatic send_near_ray();
    crd_t v[9];
    int s;
    s = $urandom_range(8);
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        v[3*k+i] = board.ray[i] + s * board.ray[3+i] +
                   crd_t'($urandom_range(6 << FRAC)) - crd_t'(3 << FRAC);
      end
    end
    send_tri(v);
  endtask

  task automatic send_noise();
    crd_t v[9];
    foreach (v[i]) v[i] = $urandom;
    send_tri(v);
  endtask

  task automatic random_mix(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 80) send_near_ray();
      else send_noise();
    end
    end_burst();
  endtask

  task automatic random_ray();
    set_ray(crd_t'($urandom_range(8 << FRAC)) - crd_t'(4 << FRAC),
            crd_t'($urandom_range(8 << FRAC)) - crd_t'(4 << FRAC),
            crd_t'($urandom_range(8 << FRAC)) - crd_t'(4 << FRAC),
            crd_t'($urandom_range(4 << FRAC)) - crd_t'(2 << FRAC),
            crd_t'($urandom_range(4 << FRAC)) - crd_t'(2 << FRAC),
            crd_t'($urandom_range(4 << FRAC)) - crd_t'(2 << FRAC));
  endtask

  initial begin
    crd_t v[9];
    board    = new();
    sent     = 0;
    idle_pct = 28;
    rst_n    = 1'b0;
    start    = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    foreach (vtx[i]) vtx[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero direction after reset: det is zero for everything
    foreach (v[i]) v[i] = 32'h7FFF_FFFF;
    send_tri(v);
    foreach (v[i]) v[i] = 32'h8000_0000;
    send_tri(v);
    end_burst();

    // ray along +z from z=-5: front and back faces, behind origin, edge case
    set_ray(0, 0, -(5 << FRAC), 0, 0, 1 << FRAC);
    v = '{-(1 << FRAC), -(1 << FRAC), 0, 0, 2 << FRAC, 0, 2 << FRAC, -(1 << FRAC), 0};
    send_tri(v);
    v = '{-(1 << FRAC), -(1 << FRAC), 0, 2 << FRAC, -(1 << FRAC), 0, 0, 2 << FRAC, 0};
    send_tri(v);
    v = '{-(1 << FRAC), -(1 << FRAC), -(9 << FRAC), 0, 2 << FRAC, -(9 << FRAC),
          2 << FRAC, -(1 << FRAC), -(9 << FRAC)};
    send_tri(v);
    v = '{0, 0, 0, 0, 1 << FRAC, 0, 1 << FRAC, 0, 0};
    send_tri(v);
    // degenerate triangle and full-scale vertices
    foreach (v[i]) v[i] = 32'h0001_0000;
    send_tri(v);
    v = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    send_tri(v);
    end_burst();

    // extreme rays
    set_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    v = '{32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF,
          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
    send_tri(v);
    send_noise();
    send_noise();
    end_burst();
    set_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_tri(v);
    send_noise();
    send_noise();
    end_burst();

    // random part: sender idles 28%, then 69%, then never
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 28 : (ph == 1) ? 69 : 0;
      for (int r = 0; r < 4; r++) begin
        random_ray();
        random_mix(60);
      end
    end
    set_ray(0, 0, 0, 1 << FRAC, 0, 0);
    random_mix(30);

    drain();
    $display("%0d triangles sent over 17 ray settings, %0d results checked, %0d hits",
             sent, board.checked, board.hits_seen);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
